>>> src/bir_pkg.sv
// Shared constants for the bilinear image resize block.
// Field widths, configuration register indexes and reset defaults.
// No dependencies.
package bir_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int CHAN_W     = 2;
  localparam int PIX_W      = 8;
  localparam int SRC_SIZE_W = 8;
  localparam int TGT_SIZE_W = 11;
  localparam int CHCNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_TDATA_W = 32;
  localparam int SIZE_W     = 13;

  localparam int BIR_MAX_SRC_WIDTH  = 128;
  localparam int BIR_MAX_SRC_HEIGHT = 128;
  localparam int BIR_MAX_CHANNELS   = 4;
  localparam int BIR_FRAC_BITS      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_WIDTH  = 8'd128;
  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_HEIGHT = 8'd128;
  localparam logic [TGT_SIZE_W-1:0] RST_TARGET_WIDTH  = 11'd128;
  localparam logic [TGT_SIZE_W-1:0] RST_TARGET_HEIGHT = 11'd128;
  localparam logic [CHCNT_W-1:0]    RST_CHANNEL_COUNT = 3'd1;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_REQUEST = 1'b1;

endpackage

>>> src/bir_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QW bits. Uses bir_pkg for the default divisor width.
module bir_div import bir_pkg::*; #(
  parameter int NW = 25,
  parameter int QW = 15,
  parameter int DW = TGT_SIZE_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [QW-1:0] bits_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] bits_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = DW'(num >> QW);
      assign bits_in = num[QW-1:0];
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign bits_in = bits_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    assign trial   = {rem_in, bits_in[QW-1]};
    assign ge      = trial >= {1'b0, den};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
    assign quo_nxt = {quo_in[QW-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        bits_r[k] <= {bits_in[QW-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

>>> src/bir_bank.sv
// One bank of the frame store: single address port, registered read.
// Depends on bir_pkg for the sample width.
module bir_bank import bir_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/bilinear_image_resize.sv
// Bilinear image resize with a four-bank frame store, fully pipelined.
// Throughput is one item per cycle; the whole pipeline advances when the
// output register is empty or taken. It holds FRAC_BITS+log2(max source size)
// divider stages plus six: input, bank read, products, row sums, column weights, output.
// Reset (rst_n low, synchronous) clears valid bits and loads register defaults.
// Frame store contents are undefined until loaded; there is no clearing pass.
module bilinear_image_resize import bir_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = BIR_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = BIR_MAX_SRC_HEIGHT,
  parameter int MAX_CHANNELS   = BIR_MAX_CHANNELS,
  parameter int FRAC_BITS      = BIR_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // col, row, chan, sample, zero pad
  input  logic [0:0]            in_tuser,  // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata, // pixel_value
  output logic [0:0]            out_tuser  // range_error
);

  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NXW   = COL_W + XW;
  localparam int NYW   = ROW_W + YW;
  localparam int QXW   = XW + FRAC_BITS;
  localparam int QYW   = YW + FRAC_BITS;
  localparam int DQ    = (QXW > QYW) ? QXW : QYW;
  localparam int FW    = FRAC_BITS + 1;
  localparam int PW    = PIX_W + FW;
  localparam int TW    = PIX_W + FRAC_BITS + 1;
  localparam int SW2   = TW + FW;
  localparam int BCOLS = (MAX_SRC_WIDTH + 1) / 2;
  localparam int BROWS = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BDEPTH = BCOLS * BROWS * MAX_CHANNELS;
  localparam int BAW   = $clog2(BDEPTH);
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  typedef struct packed {
    logic             vld;
    logic             is_req;
    logic             err;
    logic             wr_ok;
    logic [XW-1:0]    col;
    logic [YW-1:0]    row;
    logic [CHW-1:0]   chan;
    logic [PIX_W-1:0] sample;
  } item_t;

  logic [SRC_SIZE_W-1:0] src_w_r, src_h_r;
  logic [TGT_SIZE_W-1:0] tgt_w_r, tgt_h_r;
  logic [CHCNT_W-1:0]    ch_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= RST_SOURCE_WIDTH;
      src_h_r  <= RST_SOURCE_HEIGHT;
      tgt_w_r  <= RST_TARGET_WIDTH;
      tgt_h_r  <= RST_TARGET_HEIGHT;
      ch_cnt_r <= RST_CHANNEL_COUNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SOURCE_WIDTH:  src_w_r  <= cfg_wdata[SRC_SIZE_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r  <= cfg_wdata[SRC_SIZE_W-1:0];
        REG_TARGET_WIDTH:  tgt_w_r  <= cfg_wdata[TGT_SIZE_W-1:0];
        REG_TARGET_HEIGHT: tgt_h_r  <= cfg_wdata[TGT_SIZE_W-1:0];
        REG_CHANNEL_COUNT: ch_cnt_r <= cfg_wdata[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0]     sw_eff, sh_eff, ch_eff;
  logic [TGT_SIZE_W-1:0] tw_eff, th_eff;

  always_comb begin
    if (SIZE_W'(src_w_r) < SIZE_W'(2)) sw_eff = SIZE_W'(2);
    else if (SIZE_W'(src_w_r) > SIZE_W'(MAX_SRC_WIDTH)) sw_eff = SIZE_W'(MAX_SRC_WIDTH);
    else sw_eff = SIZE_W'(src_w_r);
    if (SIZE_W'(src_h_r) < SIZE_W'(2)) sh_eff = SIZE_W'(2);
    else if (SIZE_W'(src_h_r) > SIZE_W'(MAX_SRC_HEIGHT)) sh_eff = SIZE_W'(MAX_SRC_HEIGHT);
    else sh_eff = SIZE_W'(src_h_r);
    if (SIZE_W'(ch_cnt_r) < SIZE_W'(1)) ch_eff = SIZE_W'(1);
    else if (SIZE_W'(ch_cnt_r) > SIZE_W'(MAX_CHANNELS)) ch_eff = SIZE_W'(MAX_CHANNELS);
    else ch_eff = SIZE_W'(ch_cnt_r);
    tw_eff = (tgt_w_r == '0) ? TGT_SIZE_W'(1) : tgt_w_r;
    th_eff = (tgt_h_r == '0) ? TGT_SIZE_W'(1) : tgt_h_r;
  end

  logic adv;
  logic out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic out_err_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Input stage: decode, range checks and position products.
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [CHAN_W-1:0] in_chan;
  logic [15:0]       col_ext, row_ext;
  logic [3:0]        chan_ext;
  logic [XW-1:0]     swm1;
  logic [YW-1:0]     shm1;
  item_t             p0_nxt, p0_r;
  logic [NXW-1:0]    numx_nxt, numx_r;
  logic [NYW-1:0]    numy_nxt, numy_r;

  always_comb begin
    in_col   = in_tdata[COL_W-1:0];
    in_row   = in_tdata[COL_W +: ROW_W];
    in_chan  = in_tdata[COL_W+ROW_W +: CHAN_W];
    col_ext  = 16'(in_col);
    row_ext  = 16'(in_row);
    chan_ext = 4'(in_chan);
    swm1     = XW'(sw_eff - SIZE_W'(1));
    shm1     = YW'(sh_eff - SIZE_W'(1));
    p0_nxt.vld    = in_tvalid;
    p0_nxt.is_req = in_tuser[0] == REQ_REQUEST;
    p0_nxt.err    = (TGT_SIZE_W'(in_col) >= tw_eff) || (TGT_SIZE_W'(in_row) >= th_eff)
                    || (SIZE_W'(in_chan) >= ch_eff);
    p0_nxt.wr_ok  = (SIZE_W'(in_col) < sw_eff) && (SIZE_W'(in_row) < sh_eff)
                    && (SIZE_W'(in_chan) < ch_eff);
    p0_nxt.col    = col_ext[XW-1:0];
    p0_nxt.row    = row_ext[YW-1:0];
    p0_nxt.chan   = chan_ext[CHW-1:0];
    p0_nxt.sample = in_tdata[COL_W+ROW_W+CHAN_W +: PIX_W];
    numx_nxt = NXW'(in_col) * NXW'(swm1);
    numy_nxt = NYW'(in_row) * NYW'(shm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r.vld <= 1'b0;
    end else if (adv) begin
      p0_r   <= p0_nxt;
      numx_r <= numx_nxt;
      numy_r <= numy_nxt;
    end
  end

  // Division stages.
  logic [DQ-1:0] quo_x, quo_y;

  bir_div #(.NW(NXW + FRAC_BITS), .QW(DQ), .DW(TGT_SIZE_W)) u_div_x (
    .clk (clk),
    .en  (adv),
    .num ({numx_r, {FRAC_BITS{1'b0}}}),
    .den (tw_eff),
    .quo (quo_x)
  );

  bir_div #(.NW(NYW + FRAC_BITS), .QW(DQ), .DW(TGT_SIZE_W)) u_div_y (
    .clk (clk),
    .en  (adv),
    .num ({numy_r, {FRAC_BITS{1'b0}}}),
    .den (th_eff),
    .quo (quo_y)
  );

  item_t sb_div_r [DQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DQ; k++) sb_div_r[k].vld <= 1'b0;
    end else if (adv) begin
      sb_div_r[0] <= p0_r;
      for (int k = 1; k < DQ; k++) sb_div_r[k] <= sb_div_r[k-1];
    end
  end

  // Bank addressing: neighbors differ in column or row parity, so each
  // bank serves exactly one of the four.
  item_t                 sa;
  logic [XW-1:0]         ix, ix1;
  logic [YW-1:0]         iy, iy1;
  logic [FRAC_BITS-1:0]  fx, fy;
  logic [3:0]            bank_we;
  logic [BAW-1:0]        bank_addr [4];
  logic [PIX_W-1:0]      bank_rd [4];

  assign sa  = sb_div_r[DQ-1];
  assign ix  = quo_x[FRAC_BITS +: XW];
  assign iy  = quo_y[FRAC_BITS +: YW];
  assign fx  = quo_x[FRAC_BITS-1:0];
  assign fy  = quo_y[FRAC_BITS-1:0];
  assign ix1 = ix + XW'(1);
  assign iy1 = iy + YW'(1);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] bxs;
    logic [YW-1:0] bys;

    always_comb begin
      if (!sa.is_req) begin
        bxs = sa.col;
        bys = sa.row;
      end else begin
        bxs = (ix[0] == b[0]) ? ix : ix1;
        bys = (iy[0] == b[1]) ? iy : iy1;
      end
      bank_addr[b] = BAW'((32'(bys >> 1) * BCOLS + 32'(bxs >> 1)) * MAX_CHANNELS
                          + 32'(sa.chan));
      bank_we[b] = adv && sa.vld && !sa.is_req && sa.wr_ok
                   && (sa.col[0] == b[0]) && (sa.row[0] == b[1]);
    end

    bir_bank #(.DEPTH(BDEPTH), .AW(BAW)) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .re    (adv),
      .addr  (bank_addr[b]),
      .wdata (sa.sample),
      .rdata (bank_rd[b])
    );
  end

  item_t                sb_rd_r, sb_m1_r, sb_m2_r, sb_m3_r;
  logic                 x0_r, y0_r;
  logic [FRAC_BITS-1:0] fx_rd_r, fy_rd_r, fy_m1_r, fy_m2_r;

  // Blend pipeline: weights, row sums, column weights, final sum.
  logic [PIX_W-1:0] na, nb, nc, nd;
  logic [FW-1:0]    wx1, wx0, wy1, wy0;
  logic [PW-1:0]    pa_r, pb_r, pc_r, pd_r;
  logic [TW-1:0]    top_r, bot_r;
  logic [SW2-1:0]   qt_r, qb_r, fsum;

  assign na  = bank_rd[{y0_r, x0_r}];
  assign nb  = bank_rd[{y0_r, !x0_r}];
  assign nc  = bank_rd[{!y0_r, x0_r}];
  assign nd  = bank_rd[{!y0_r, !x0_r}];
  assign wx1 = FW'(fx_rd_r);
  assign wx0 = ONE - wx1;
  assign wy1 = FW'(fy_m2_r);
  assign wy0 = ONE - wy1;
  assign fsum = qt_r + qb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_rd_r.vld <= 1'b0;
      sb_m1_r.vld <= 1'b0;
      sb_m2_r.vld <= 1'b0;
      sb_m3_r.vld <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sb_rd_r <= sa;
      x0_r    <= ix[0];
      y0_r    <= iy[0];
      fx_rd_r <= fx;
      fy_rd_r <= fy;
      sb_m1_r <= sb_rd_r;
      fy_m1_r <= fy_rd_r;
      pa_r    <= PW'(na) * PW'(wx0);
      pb_r    <= PW'(nb) * PW'(wx1);
      pc_r    <= PW'(nc) * PW'(wx0);
      pd_r    <= PW'(nd) * PW'(wx1);
      sb_m2_r <= sb_m1_r;
      fy_m2_r <= fy_m1_r;
      top_r   <= TW'(pa_r) + TW'(pb_r);
      bot_r   <= TW'(pc_r) + TW'(pd_r);
      sb_m3_r <= sb_m2_r;
      qt_r    <= SW2'(top_r) * SW2'(wy0);
      qb_r    <= SW2'(bot_r) * SW2'(wy1);
      out_valid_r <= sb_m3_r.vld && sb_m3_r.is_req;
      out_err_r   <= sb_m3_r.err;
      out_data_r  <= sb_m3_r.err ? '0 : fsum[2*FRAC_BITS +: PIX_W];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_data_r == '0)
    else $error("range error result carries nonzero pixel");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one frame store bank written");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sb_m3_r.vld) && $stable(out_data_r))
    else $error("pipeline moved during a stall");
`endif

endmodule
